/* sv/pttlb_pkg.sv */
// ----------------------------------------------------------------------------
// pttlb_pkg
// Shared types, codes and defaults for the page table / TLB translator.
// ----------------------------------------------------------------------------
package pttlb_pkg;

  // Default geometry
  localparam int ENTRIES_DEF    = 64;
  localparam int PAGE_BYTES_DEF = 128;   // power of two, 16..65536

  // Field widths
  localparam int VA_W      = 32;
  localparam int VPN_W     = 25;
  localparam int PPN_W     = 10;
  localparam int SLOT_W    = 6;
  localparam int PA_W      = 17;
  localparam int LIM_W     = 7;
  localparam int PAGES_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  // Commands
  localparam logic [1:0] CMD_XLATE = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  // Alignment masks
  localparam logic [1:0] ALIGN_WORD_MASK = 2'h3;
  localparam logic [1:0] ALIGN_HALF_MASK = 2'h1;

  // Result status
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_FAULT = 3'd2;
  localparam logic [2:0] ST_RO    = 3'd3;
  localparam logic [2:0] ST_BUS   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_PAGES  = 2'd2;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;

  // Reset values of configuration
  localparam logic [LIM_W-1:0]   ENTRIES_USE_RST = 7'd64;
  localparam logic [PAGES_W-1:0] PHYS_PAGES_RST  = 11'd32;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [VA_W-1:0]  virt_addr;
    logic [1:0]       size_code;
    logic             is_write;
    logic [SLOT_W-1:0] slot;
    logic [VPN_W-1:0] new_vpn;
    logic [PPN_W-1:0] new_ppn;
    logic             new_valid;
    logic             new_read_only;
    logic             new_use;
    logic             new_dirty;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [PA_W-1:0]  phys_addr;
    logic [VPN_W-1:0] rd_vpn;
    logic [PPN_W-1:0] rd_ppn;
    logic             rd_valid;
    logic             rd_read_only;
    logic             rd_use;
    logic             rd_dirty;
  } out_item_t;

  typedef struct packed {
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
    logic             valid;
    logic             read_only;
    logic             use_bit;
    logic             dirty;
  } entry_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       clr;        // write zero at clear pointer, advance
    logic       latch;      // capture request
    logic       rd_slot;    // read entry at request slot
    logic       rd_vpn;     // read entry at page number
    logic       rd_first;   // read entry 0
    logic       rd_next;    // read entry after current
    logic       wr_entry;   // store request entry at slot
    logic       wr_back;    // set use/dirty on current entry
    logic       emit;       // load result register
    logic [2:0] emit_status;
    logic       emit_pa;
    logic       emit_rd;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       mode;
    logic       align_bad;
    logic       slot_bad;
    logic       lin_range_bad;
    logic       lim_zero;
    logic       hit_valid;
    logic       vpn_match;
    logic       scan_last;
    logic       ro_bad;
    logic       bus_bad;
  } dp_status_t;

endpackage

/* sv/pttlb_dp.sv */
// ----------------------------------------------------------------------------
// pttlb_dp
// Datapath: request register, entry store, config registers, result register.
// ----------------------------------------------------------------------------
module pttlb_dp #(
  parameter int ENTRIES    = pttlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BYTES = pttlb_pkg::PAGE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pttlb_pkg::in_item_t                 in_item,
  input  logic                                cfg_we,
  input  logic [pttlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pttlb_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  pttlb_pkg::dp_cmd_t                  cmd,
  output pttlb_pkg::dp_status_t               status,
  output logic                                out_valid,
  output pttlb_pkg::out_item_t                out_item
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OFF_W = $clog2(PAGE_BYTES);

  // Config registers
  logic                            mode_r;
  logic [pttlb_pkg::LIM_W-1:0]     use_cnt_r;
  logic [pttlb_pkg::PAGES_W-1:0]   pages_r;

  // Control registers
  logic [IDX_W-1:0]                clr_r;
  logic                            out_valid_r;

  // Payload registers
  pttlb_pkg::in_item_t             req_r;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  pttlb_pkg::entry_t               rd_data_r;
  pttlb_pkg::out_item_t            out_r;

  // Entry store
  pttlb_pkg::entry_t               mem [ENTRIES];

  logic                            mem_we, mem_re;
  logic [IDX_W-1:0]                mem_waddr;
  pttlb_pkg::entry_t               mem_wdata;

  logic [31:0]                     vpn_full;
  logic [IDX_W-1:0]                slot_idx, vpn_idx;
  logic [pttlb_pkg::LIM_W-1:0]     lim;
  logic [31:0]                     pa_full;
  logic [1:0]                      va_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pttlb_pkg::MODE_ASSOC;
      use_cnt_r <= pttlb_pkg::ENTRIES_USE_RST;
      pages_r   <= pttlb_pkg::PHYS_PAGES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pttlb_pkg::CFG_LOOKUP_MODE: mode_r    <= cfg_wdata[0];
        pttlb_pkg::CFG_ENTRIES_USE: use_cnt_r <= cfg_wdata[pttlb_pkg::LIM_W-1:0];
        pttlb_pkg::CFG_PHYS_PAGES:  pages_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective entry count, capped by store depth
  always_comb begin
    if (32'(use_cnt_r) > 32'(ENTRIES)) begin
      lim = pttlb_pkg::LIM_W'(ENTRIES);
    end else begin
      lim = use_cnt_r;
    end
  end

  assign vpn_full = req_r.virt_addr >> OFF_W;
  assign vpn_idx  = vpn_full[IDX_W-1:0];
  assign slot_idx = IDX_W'(32'(req_r.slot));
  assign va_low   = req_r.virt_addr[1:0];
  assign pa_full  = 32'({rd_data_r.ppn, req_r.virt_addr[OFF_W-1:0]});

  // Next scan / read index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.rd_slot) begin
      idx_nxt = slot_idx;
    end else if (cmd.rd_vpn) begin
      idx_nxt = vpn_idx;
    end else if (cmd.rd_first) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  assign mem_re = cmd.rd_slot | cmd.rd_vpn | cmd.rd_first | cmd.rd_next;

  // Write port select
  always_comb begin
    mem_we    = cmd.clr | cmd.wr_entry | cmd.wr_back;
    mem_waddr = idx_r;
    mem_wdata = rd_data_r;
    if (cmd.clr) begin
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (cmd.wr_entry) begin
      mem_waddr           = slot_idx;
      mem_wdata.vpn       = req_r.new_vpn;
      mem_wdata.ppn       = req_r.new_ppn;
      mem_wdata.valid     = req_r.new_valid;
      mem_wdata.read_only = req_r.new_read_only;
      mem_wdata.use_bit   = req_r.new_use;
      mem_wdata.dirty     = req_r.new_dirty;
    end else if (cmd.wr_back) begin
      mem_wdata.use_bit = 1'b1;
      mem_wdata.dirty   = rd_data_r.dirty | req_r.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      req_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + IDX_W'(1);
    end
  end

  // Status to controller
  always_comb begin
    status.clr_last      = (32'(clr_r) == 32'(ENTRIES - 1));
    status.cmd           = req_r.cmd;
    status.mode          = mode_r;
    status.align_bad     = (req_r.size_code == pttlb_pkg::SZ_BAD) ||
                           ((req_r.size_code == pttlb_pkg::SZ_WORD) &&
                            ((va_low & pttlb_pkg::ALIGN_WORD_MASK) != 2'd0)) ||
                           ((req_r.size_code == pttlb_pkg::SZ_HALF) &&
                            ((va_low & pttlb_pkg::ALIGN_HALF_MASK) != 2'd0));
    status.slot_bad      = (32'(req_r.slot) >= 32'(ENTRIES));
    status.lin_range_bad = (vpn_full >= 32'(lim));
    status.lim_zero      = (lim == '0);
    status.hit_valid     = rd_data_r.valid;
    status.vpn_match     = (32'(rd_data_r.vpn) == vpn_full);
    status.scan_last     = ((32'(idx_r) + 32'd1) >= 32'(lim));
    status.ro_bad        = rd_data_r.read_only & req_r.is_write;
    status.bus_bad       = ({1'b0, rd_data_r.ppn} >= pages_r);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status       <= cmd.emit_status;
      out_r.phys_addr    <= cmd.emit_pa ? pa_full[pttlb_pkg::PA_W-1:0] : '0;
      out_r.rd_vpn       <= cmd.emit_rd ? rd_data_r.vpn       : '0;
      out_r.rd_ppn       <= cmd.emit_rd ? rd_data_r.ppn       : '0;
      out_r.rd_valid     <= cmd.emit_rd ? rd_data_r.valid     : 1'b0;
      out_r.rd_read_only <= cmd.emit_rd ? rd_data_r.read_only : 1'b0;
      out_r.rd_use       <= cmd.emit_rd ? rd_data_r.use_bit   : 1'b0;
      out_r.rd_dirty     <= cmd.emit_rd ? rd_data_r.dirty     : 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* sv/pttlb_ctrl.sv */
// ----------------------------------------------------------------------------
// pttlb_ctrl
// Controller FSM: clear pass, dispatch, linear lookup, associative scan.
// ----------------------------------------------------------------------------
module pttlb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  pttlb_pkg::dp_status_t   status,
  output pttlb_pkg::dp_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DISP  = 6'b000100,
    S_LWAIT = 6'b001000,
    S_SCAN  = 6'b010000,
    S_RWAIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Entry found: permission and frame checks, then update or reject
  function automatic pttlb_pkg::dp_cmd_t finish(input pttlb_pkg::dp_status_t st);
    pttlb_pkg::dp_cmd_t c;
    c      = '0;
    c.emit = 1'b1;
    if (st.ro_bad) begin
      c.emit_status = pttlb_pkg::ST_RO;
    end else if (st.bus_bad) begin
      c.emit_status = pttlb_pkg::ST_BUS;
    end else begin
      c.emit_status = pttlb_pkg::ST_OK;
      c.emit_pa     = 1'b1;
      c.wr_back     = 1'b1;
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (status.cmd)
          pttlb_pkg::CMD_XLATE: begin
            if (status.align_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pttlb_pkg::ST_ADDR;
            end else if (status.mode == pttlb_pkg::MODE_LINEAR) begin
              if (status.lin_range_bad) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = pttlb_pkg::ST_ADDR;
              end else begin
                cmd.rd_vpn = 1'b1;
                state_nxt  = S_LWAIT;
              end
            end else if (status.lim_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pttlb_pkg::ST_FAULT;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          pttlb_pkg::CMD_WRITE: begin
            cmd.emit = 1'b1;
            if (status.slot_bad) begin
              cmd.emit_status = pttlb_pkg::ST_ADDR;
            end else begin
              cmd.emit_status = pttlb_pkg::ST_OK;
              cmd.wr_entry    = 1'b1;
            end
          end
          pttlb_pkg::CMD_READ: begin
            if (status.slot_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = pttlb_pkg::ST_ADDR;
            end else begin
              cmd.rd_slot = 1'b1;
              state_nxt   = S_RWAIT;
            end
          end
          default: begin
            // unknown command: all-zero result
            cmd.emit        = 1'b1;
            cmd.emit_status = pttlb_pkg::ST_OK;
          end
        endcase
      end
      S_LWAIT: begin
        state_nxt = S_IDLE;
        if (!status.hit_valid) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = pttlb_pkg::ST_FAULT;
        end else begin
          cmd = finish(status);
        end
      end
      S_SCAN: begin
        if (status.hit_valid && status.vpn_match) begin
          cmd       = finish(status);
          state_nxt = S_IDLE;
        end else if (status.scan_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = pttlb_pkg::ST_FAULT;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_RWAIT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = pttlb_pkg::ST_OK;
        cmd.emit_rd     = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* sv/page_table_and_tlb_translator_core.sv */
// ----------------------------------------------------------------------------
// page_table_and_tlb_translator_core
// Virtual-to-physical translator with a linear page table / associative TLB.
// ----------------------------------------------------------------------------
// Issue a request by raising start while busy is low; it is taken at that
// edge. Exactly one result follows per request, shown for a single cycle with
// out_valid high: the receiver cannot stall, so it must capture it then.
// busy drops in the cycle the result appears, so the next request can be
// taken at the edge that ends it. Write entry, unknown command and early
// rejects (misalignment, bad slot, linear out of range) are answered from
// the dispatch state; read entry and linear translate first read one entry
// into a register; associative translate reads entries one at a time until
// it has scanned hit position + 1 entries, or the effective entry count
// on a miss. The associative search walks the entry store one entry per
// cycle; that read loop sets the rate. After reset the store is cleared
// one entry per cycle with busy high; config writes are taken during the
// clear. PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module page_table_and_tlb_translator_core #(
  parameter int ENTRIES    = pttlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BYTES = pttlb_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  pttlb_pkg::in_item_t               in_item,
  // result channel
  output logic                              out_valid,
  output pttlb_pkg::out_item_t              out_item,
  // config write port
  input  logic                              cfg_we,
  input  logic [pttlb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pttlb_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  // controller <-> datapath
  pttlb_pkg::dp_cmd_t     dp_cmd;
  pttlb_pkg::dp_status_t  dp_status;

  pttlb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (dp_status),
    .cmd    (dp_cmd)
  );

  pttlb_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
